FILE: rtl/fqs_pkg.sv
// Shared types and codes for the queue with key search.
package fqs_pkg;

	localparam int QUEUE_DEPTH_DEF = 16;
	localparam int WORD_W          = 32;
	localparam int POS_W           = 4;
	localparam int ENTRY_W         = 5;

	localparam logic [1:0] OP_PUSH   = 2'd0;
	localparam logic [1:0] OP_POP    = 2'd1;
	localparam logic [1:0] OP_SEARCH = 2'd2;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_FULL      = 2'd1;
	localparam logic [1:0] ST_EMPTY     = 2'd2;
	localparam logic [1:0] ST_NOT_FOUND = 2'd3;

	typedef struct packed {
		logic [1:0]               operation;
		logic signed [WORD_W-1:0] data_word;
		logic signed [WORD_W-1:0] move_count;
	} cmd_t;

	typedef struct packed {
		logic [1:0]               status;
		logic signed [WORD_W-1:0] out_data;
		logic signed [WORD_W-1:0] out_moves;
		logic [POS_W-1:0]         found_position;
		logic [ENTRY_W-1:0]       entry_count;
	} result_t;

	typedef struct packed {
		logic signed [WORD_W-1:0] data;
		logic signed [WORD_W-1:0] moves;
	} entry_t;

	typedef struct packed {
		logic             hit;
		entry_t           ent;
		logic [POS_W-1:0] pos;
	} res_t;

	typedef struct packed {
		logic push;
		logic pop;
		logic clear;
		logic step;
	} cell_ctrl_t;

endpackage

FILE: rtl/fqs_cell.sv
// One queue slot: holds an entry, shifts toward the front, and forwards search hits.
module fqs_cell #(
	parameter int CNT_W = 5,
	parameter int INDEX = 0
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  fqs_pkg::cell_ctrl_t                ctrl,
	input  logic [CNT_W-1:0]                   count,
	input  logic signed [fqs_pkg::WORD_W-1:0]  key,
	input  fqs_pkg::entry_t                    wr,
	input  fqs_pkg::entry_t                    nxt_entry,
	output fqs_pkg::entry_t                    entry,
	input  fqs_pkg::res_t                      nxt_res,
	output fqs_pkg::res_t                      res
);

	localparam logic [CNT_W-1:0]          IDX = CNT_W'(INDEX);
	localparam logic [fqs_pkg::POS_W-1:0] POS = fqs_pkg::POS_W'(INDEX);

	fqs_pkg::entry_t                entry_q;
	fqs_pkg::entry_t                hit_ent_q;
	logic [fqs_pkg::POS_W-1:0]      hit_pos_q;
	logic                           hit_q;
	logic                           live;
	logic                           match;

	assign live  = IDX < count;
	assign match = live && (entry_q.data == key);

	always_ff @(posedge clk) begin
		if (ctrl.pop) begin
			entry_q <= nxt_entry;
		end else if (ctrl.push && (count == IDX)) begin
			entry_q <= wr;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q <= 1'b0;
		end else if (ctrl.clear) begin
			hit_q <= 1'b0;
		end else if (ctrl.step) begin
			hit_q <= match ? 1'b1 : nxt_res.hit;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.step) begin
			hit_ent_q <= match ? entry_q : nxt_res.ent;
			hit_pos_q <= match ? POS : nxt_res.pos;
		end
	end

	assign entry = entry_q;
	assign res   = '{hit: hit_q, ent: hit_ent_q, pos: hit_pos_q};

endmodule

FILE: rtl/fifo_queue_with_search.sv
// Top level: bounded queue built as a chain of cells, with front-first key search.
//
// Push and pop are taken while idle and their result appears on the cycle after the
// transfer, so a new command may follow every cycle. A search keeps busy high through
// the walk and report states and strobes its result on the cycle after that: each
// cell compares the key with its entry in parallel, and the hit walks one cell per cycle
// toward the front, the front-most match overriding those behind it. The result stays on
// the result port until the next command is taken, marked by done for a single cycle; the
// receiver cannot stall, so it must capture the transfer in that cycle.
module fifo_queue_with_search #(
	parameter int QUEUE_DEPTH = fqs_pkg::QUEUE_DEPTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  fqs_pkg::cmd_t    cmd,
	output logic             done,
	output fqs_pkg::result_t result
);

	localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
	localparam int ENTRY_W = fqs_pkg::ENTRY_W;
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

	typedef enum logic [1:0] {
		S_IDLE,
		S_SEARCH,
		S_REPORT
	} state_t;

	state_t                             state_q;
	logic [CNT_W-1:0]                   count_q;
	logic [CNT_W-1:0]                   steps_q;
	logic signed [fqs_pkg::WORD_W-1:0]  key_q;
	logic                               done_q;
	fqs_pkg::result_t                   result_q;

	fqs_pkg::cell_ctrl_t                ctrl;
	fqs_pkg::entry_t                    wr;
	fqs_pkg::entry_t                    ent  [QUEUE_DEPTH];
	fqs_pkg::res_t                      rs   [QUEUE_DEPTH];
	logic                               take;
	logic                               full;
	logic                               empty;

	assign take  = start && !busy;
	assign full  = count_q == FULL_CNT;
	assign empty = count_q == '0;

	assign wr = '{data: cmd.data_word, moves: cmd.move_count};

	always_comb begin
		ctrl.push  = take && (cmd.operation == fqs_pkg::OP_PUSH) && !full;
		ctrl.pop   = take && (cmd.operation == fqs_pkg::OP_POP) && !empty;
		ctrl.clear = take && (cmd.operation == fqs_pkg::OP_SEARCH);
		ctrl.step  = state_q == S_SEARCH;
	end

	for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
		fqs_pkg::entry_t nxt_entry;
		fqs_pkg::res_t   nxt_res;

		if (i == QUEUE_DEPTH - 1) begin : g_last
			assign nxt_entry = '0;
			assign nxt_res   = '0;
		end else begin : g_mid
			assign nxt_entry = ent[i+1];
			assign nxt_res   = rs[i+1];
		end

		fqs_cell #(
			.CNT_W (CNT_W),
			.INDEX (i)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctrl      (ctrl),
			.count     (count_q),
			.key       (key_q),
			.wr        (wr),
			.nxt_entry (nxt_entry),
			.entry     (ent[i]),
			.nxt_res   (nxt_res),
			.res       (rs[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			steps_q <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (take) begin
						unique case (cmd.operation)
							fqs_pkg::OP_PUSH: begin
								done_q <= 1'b1;
								if (!full) begin
									count_q <= count_q + 1'b1;
								end
							end
							fqs_pkg::OP_POP: begin
								done_q <= 1'b1;
								if (!empty) begin
									count_q <= count_q - 1'b1;
								end
							end
							fqs_pkg::OP_SEARCH: begin
								steps_q <= empty ? CNT_W'(1) : count_q;
								state_q <= S_SEARCH;
							end
							default: begin
								done_q <= 1'b1;
							end
						endcase
					end
				end
				S_SEARCH: begin
					steps_q <= steps_q - 1'b1;
					if (steps_q == CNT_W'(1)) begin
						state_q <= S_REPORT;
					end
				end
				S_REPORT: begin
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (take && (cmd.operation == fqs_pkg::OP_SEARCH)) begin
			key_q <= cmd.data_word;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_REPORT) begin
			result_q.status         <= rs[0].hit ? fqs_pkg::ST_OK : fqs_pkg::ST_NOT_FOUND;
			result_q.out_data       <= rs[0].hit ? rs[0].ent.data : '0;
			result_q.out_moves      <= rs[0].hit ? rs[0].ent.moves : '0;
			result_q.found_position <= rs[0].hit ? rs[0].pos : '0;
			result_q.entry_count    <= ENTRY_W'(count_q);
		end else if (take) begin
			result_q.out_data       <= '0;
			result_q.out_moves      <= '0;
			result_q.found_position <= '0;
			result_q.status         <= fqs_pkg::ST_OK;
			result_q.entry_count    <= ENTRY_W'(count_q);
			case (cmd.operation)
				fqs_pkg::OP_PUSH: begin
					if (full) begin
						result_q.status <= fqs_pkg::ST_FULL;
					end else begin
						result_q.entry_count <= ENTRY_W'(count_q + 1'b1);
					end
				end
				fqs_pkg::OP_POP: begin
					if (empty) begin
						result_q.status <= fqs_pkg::ST_EMPTY;
					end else begin
						result_q.out_data    <= ent[0].data;
						result_q.out_moves   <= ent[0].moves;
						result_q.entry_count <= ENTRY_W'(count_q - 1'b1);
					end
				end
				default: begin
				end
			endcase
		end
	end

	assign busy   = state_q != S_IDLE;
	assign done   = done_q;
	assign result = result_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= FULL_CNT)
		else $error("entry count beyond queue depth");

	a_no_done_in_search: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SEARCH) |-> !done_q)
		else $error("result strobe during search walk");

	a_push_grows: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.push |=> (count_q == $past(count_q) + 1'b1))
		else $error("push did not add an entry");

	a_pop_shrinks: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.pop |=> (count_q == $past(count_q) - 1'b1))
		else $error("pop did not remove an entry");

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && (result_q.status == fqs_pkg::ST_NOT_FOUND)) |->
		((result_q.out_data == '0) && (result_q.found_position == '0)))
		else $error("search miss carries entry data");

endmodule
